// File: rtl/gpio_bank_set_clear_registers_unit_defines.svh
// Assertion helpers for the pin bank checker.
`ifndef GPIO_BANK_SET_CLEAR_REGISTERS_UNIT_DEFINES_SVH
`define GPIO_BANK_SET_CLEAR_REGISTERS_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define GBSC_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gbsc: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define GBSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gbsc: next-cycle check failed");

`endif

// File: rtl/gbsc_pkg.sv
package gbsc_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SEL_W        = 5;
  localparam int unsigned PIN_COUNT    = 32;
  localparam int unsigned DIVIDER_BITS = 14;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef enum logic [SEL_W-1:0] {
    REG_OWN_SET, REG_OWN_CLR, REG_OWN_STAT,
    REG_OE_SET,  REG_OE_CLR,  REG_OE_STAT,
    REG_LVL_SET, REG_LVL_CLR, REG_LVL_STAT,
    REG_FLT_SET, REG_FLT_CLR, REG_FLT_STAT,
    REG_DEB_SET, REG_DEB_CLR, REG_DEB_STAT,
    REG_OD_SET,  REG_OD_CLR,  REG_OD_STAT,
    REG_PU_EN,   REG_PU_DIS,  REG_PU_STAT,
    REG_PD_SET,  REG_PD_CLR,  REG_PD_STAT,
    REG_SEL_ONE, REG_SEL_TWO, REG_SCHMITT, REG_DIVIDER,
    REG_PIN_DATA, REG_IRQ_DIS, REG_LEGACY_A, REG_LEGACY_B
  } reg_e;

  typedef enum logic [2:0] {
    OP_NOP, OP_SET, OP_CLR, OP_WRITE, OP_READ
  } op_e;

  typedef enum logic [3:0] {
    TGT_OWN, TGT_OE, TGT_LVL, TGT_FLT, TGT_DEB, TGT_OD, TGT_PU, TGT_PD,
    TGT_SEL_ONE, TGT_SEL_TWO, TGT_SCHMITT, TGT_DIVIDER, TGT_PADS, TGT_NONE
  } tgt_e;

  typedef struct packed {
    op_e               op;
    tgt_e              tgt;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] pads;
  } cmd_t;

endpackage

// File: rtl/gbsc_in_if.sv
interface gbsc_in_if import gbsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SEL_W-1:0]  reg_select;
  logic [DATA_W-1:0] write_data;
  logic [DATA_W-1:0] pad_levels;

  modport source (output valid, action, reg_select, write_data, pad_levels, input ready);
  modport sink   (input valid, action, reg_select, write_data, pad_levels, output ready);
endinterface

// File: rtl/gbsc_out_if.sv
interface gbsc_out_if import gbsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] pad_out_level;
  logic [DATA_W-1:0] pad_out_enable;
  logic [DATA_W-1:0] pull_up_on;
  logic [DATA_W-1:0] pull_down_on;
  logic [DATA_W-1:0] filter_on;
  logic [DATA_W-1:0] periph_sel_low;
  logic [DATA_W-1:0] periph_sel_high;

  modport source (
    output valid, read_data, pad_out_level, pad_out_enable, pull_up_on,
           pull_down_on, filter_on, periph_sel_low, periph_sel_high,
    input  ready
  );
  modport sink (
    input  valid, read_data, pad_out_level, pad_out_enable, pull_up_on,
           pull_down_on, filter_on, periph_sel_low, periph_sel_high,
    output ready
  );
endinterface

// File: rtl/gbsc_front.sv
module gbsc_front import gbsc_pkg::*; (
  gbsc_in_if.sink in_i,
  output logic    push_valid_o,
  output cmd_t    push_cmd_o,
  input  logic    push_ready_i
);

  op_e  op;
  tgt_e tgt;
  logic wr;

  assign wr = in_i.action;

  // Classify access: status read, word regs read/write, set/clear pairs update.
  always_comb begin
    op  = OP_NOP;
    tgt = TGT_NONE;
    case (reg_e'(in_i.reg_select))
      REG_OWN_SET:  begin tgt = TGT_OWN; op = wr ? OP_SET : OP_NOP; end
      REG_OWN_CLR:  begin tgt = TGT_OWN; op = wr ? OP_CLR : OP_NOP; end
      REG_OWN_STAT: begin tgt = TGT_OWN; op = wr ? OP_NOP : OP_READ; end
      REG_OE_SET:   begin tgt = TGT_OE;  op = wr ? OP_SET : OP_NOP; end
      REG_OE_CLR:   begin tgt = TGT_OE;  op = wr ? OP_CLR : OP_NOP; end
      REG_OE_STAT:  begin tgt = TGT_OE;  op = wr ? OP_NOP : OP_READ; end
      REG_LVL_SET:  begin tgt = TGT_LVL; op = wr ? OP_SET : OP_NOP; end
      REG_LVL_CLR:  begin tgt = TGT_LVL; op = wr ? OP_CLR : OP_NOP; end
      REG_LVL_STAT: begin tgt = TGT_LVL; op = wr ? OP_NOP : OP_READ; end
      REG_FLT_SET:  begin tgt = TGT_FLT; op = wr ? OP_SET : OP_NOP; end
      REG_FLT_CLR:  begin tgt = TGT_FLT; op = wr ? OP_CLR : OP_NOP; end
      REG_FLT_STAT: begin tgt = TGT_FLT; op = wr ? OP_NOP : OP_READ; end
      REG_DEB_SET:  begin tgt = TGT_DEB; op = wr ? OP_SET : OP_NOP; end
      REG_DEB_CLR:  begin tgt = TGT_DEB; op = wr ? OP_CLR : OP_NOP; end
      REG_DEB_STAT: begin tgt = TGT_DEB; op = wr ? OP_NOP : OP_READ; end
      REG_OD_SET:   begin tgt = TGT_OD;  op = wr ? OP_SET : OP_NOP; end
      REG_OD_CLR:   begin tgt = TGT_OD;  op = wr ? OP_CLR : OP_NOP; end
      REG_OD_STAT:  begin tgt = TGT_OD;  op = wr ? OP_NOP : OP_READ; end
      // pull-up state is stored inverted: enable clears, disable sets
      REG_PU_EN:    begin tgt = TGT_PU;  op = wr ? OP_CLR : OP_NOP; end
      REG_PU_DIS:   begin tgt = TGT_PU;  op = wr ? OP_SET : OP_NOP; end
      REG_PU_STAT:  begin tgt = TGT_PU;  op = wr ? OP_NOP : OP_READ; end
      REG_PD_SET:   begin tgt = TGT_PD;  op = wr ? OP_SET : OP_NOP; end
      REG_PD_CLR:   begin tgt = TGT_PD;  op = wr ? OP_CLR : OP_NOP; end
      REG_PD_STAT:  begin tgt = TGT_PD;  op = wr ? OP_NOP : OP_READ; end
      REG_SEL_ONE:  begin tgt = TGT_SEL_ONE; op = wr ? OP_WRITE : OP_READ; end
      REG_SEL_TWO:  begin tgt = TGT_SEL_TWO; op = wr ? OP_WRITE : OP_READ; end
      REG_SCHMITT:  begin tgt = TGT_SCHMITT; op = wr ? OP_WRITE : OP_READ; end
      REG_DIVIDER:  begin tgt = TGT_DIVIDER; op = wr ? OP_WRITE : OP_READ; end
      REG_PIN_DATA: begin tgt = TGT_PADS;    op = wr ? OP_NOP : OP_READ; end
      REG_IRQ_DIS:  begin tgt = TGT_NONE;    op = OP_NOP; end
      REG_LEGACY_A: begin tgt = TGT_SEL_ONE; op = wr ? OP_CLR : OP_NOP; end
      REG_LEGACY_B: begin tgt = TGT_SEL_ONE; op = wr ? OP_SET : OP_NOP; end
      default:      begin tgt = TGT_NONE;    op = OP_NOP; end
    endcase
  end

  assign push_valid_o    = in_i.valid;
  assign push_cmd_o.op   = op;
  assign push_cmd_o.tgt  = tgt;
  assign push_cmd_o.data = in_i.write_data;
  assign push_cmd_o.pads = in_i.pad_levels;
  assign in_i.ready      = push_ready_i;

endmodule

// File: rtl/gbsc_fifo.sv
module gbsc_fifo import gbsc_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: rtl/gbsc_back.sv
module gbsc_back import gbsc_pkg::*; #(
  parameter int unsigned PinCount    = PIN_COUNT,
  parameter int unsigned DividerBits = DIVIDER_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  input  cmd_t        pop_cmd_i,
  output logic        pop_ready_o,
  gbsc_out_if.source  out_o
);

  typedef logic [PinCount-1:0] pins_t;

  pins_t own_q, own_d, oe_q, oe_d, lvl_q, lvl_d, flt_q, flt_d;
  pins_t deb_q, deb_d, od_q, od_d, pu_off_q, pu_off_d, pd_q, pd_d;
  pins_t sel1_q, sel1_d, sel2_q, sel2_d, sch_q, sch_d;
  logic [DividerBits-1:0] div_q, div_d;

  logic              out_valid_q;
  logic              exec;
  logic [DATA_W-1:0] rd;
  pins_t             wm;

  logic [DATA_W-1:0] rd_q, lvl_o_q, oe_o_q, pu_o_q, pd_o_q, flt_o_q, sl_o_q, sh_o_q;

  function automatic pins_t apply(op_e op, pins_t cur, pins_t m);
    pins_t r;
    case (op)
      OP_SET:   r = cur | m;
      OP_CLR:   r = cur & ~m;
      OP_WRITE: r = m;
      default:  r = cur;
    endcase
    return r;
  endfunction

  // Take the next beat whenever the output register is free or being drained.
  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign exec        = pop_valid_i && pop_ready_o;
  assign wm          = pop_cmd_i.data[PinCount-1:0];

  always_comb begin
    own_d    = own_q;
    oe_d     = oe_q;
    lvl_d    = lvl_q;
    flt_d    = flt_q;
    deb_d    = deb_q;
    od_d     = od_q;
    pu_off_d = pu_off_q;
    pd_d     = pd_q;
    sel1_d   = sel1_q;
    sel2_d   = sel2_q;
    sch_d    = sch_q;
    div_d    = div_q;
    if (exec) begin
      case (pop_cmd_i.tgt)
        TGT_OWN:     own_d    = apply(pop_cmd_i.op, own_q, wm);
        TGT_OE:      oe_d     = apply(pop_cmd_i.op, oe_q, wm);
        TGT_LVL:     lvl_d    = apply(pop_cmd_i.op, lvl_q, wm);
        TGT_FLT:     flt_d    = apply(pop_cmd_i.op, flt_q, wm);
        TGT_DEB:     deb_d    = apply(pop_cmd_i.op, deb_q, wm);
        TGT_OD:      od_d     = apply(pop_cmd_i.op, od_q, wm);
        TGT_PU:      pu_off_d = apply(pop_cmd_i.op, pu_off_q, wm);
        TGT_PD:      pd_d     = apply(pop_cmd_i.op, pd_q, wm);
        TGT_SEL_ONE: sel1_d   = apply(pop_cmd_i.op, sel1_q, wm);
        TGT_SEL_TWO: sel2_d   = apply(pop_cmd_i.op, sel2_q, wm);
        TGT_SCHMITT: sch_d    = apply(pop_cmd_i.op, sch_q, wm);
        TGT_DIVIDER: begin
          if (pop_cmd_i.op == OP_WRITE) begin
            div_d = pop_cmd_i.data[DividerBits-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Reads leave state untouched, so the current value is the answer.
  always_comb begin
    rd = '0;
    if (pop_cmd_i.op == OP_READ) begin
      case (pop_cmd_i.tgt)
        TGT_OWN:     rd = DATA_W'(own_q);
        TGT_OE:      rd = DATA_W'(oe_q);
        TGT_LVL:     rd = DATA_W'(lvl_q);
        TGT_FLT:     rd = DATA_W'(flt_q);
        TGT_DEB:     rd = DATA_W'(deb_q);
        TGT_OD:      rd = DATA_W'(od_q);
        TGT_PU:      rd = DATA_W'(pu_off_q);
        TGT_PD:      rd = DATA_W'(pd_q);
        TGT_SEL_ONE: rd = DATA_W'(sel1_q);
        TGT_SEL_TWO: rd = DATA_W'(sel2_q);
        TGT_SCHMITT: rd = DATA_W'(sch_q);
        TGT_DIVIDER: rd = DATA_W'(div_q);
        TGT_PADS:    rd = DATA_W'(pop_cmd_i.pads[PinCount-1:0]);
        default:     rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q       <= '1;
      oe_q        <= '0;
      lvl_q       <= '0;
      flt_q       <= '0;
      deb_q       <= '0;
      od_q        <= '0;
      pu_off_q    <= '0;
      pd_q        <= '0;
      sel1_q      <= '0;
      sel2_q      <= '0;
      sch_q       <= '0;
      div_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      own_q       <= own_d;
      oe_q        <= oe_d;
      lvl_q       <= lvl_d;
      flt_q       <= flt_d;
      deb_q       <= deb_d;
      od_q        <= od_d;
      pu_off_q    <= pu_off_d;
      pd_q        <= pd_d;
      sel1_q      <= sel1_d;
      sel2_q      <= sel2_d;
      sch_q       <= sch_d;
      div_q       <= div_d;
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result beat shows the pad controls after the access has taken effect.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      rd_q    <= rd;
      lvl_o_q <= DATA_W'(lvl_d);
      oe_o_q  <= DATA_W'(own_d & oe_d & ~(od_d & lvl_d));
      pu_o_q  <= DATA_W'(~pu_off_d);
      pd_o_q  <= DATA_W'(pd_d);
      flt_o_q <= DATA_W'(flt_d);
      sl_o_q  <= DATA_W'(sel1_d);
      sh_o_q  <= DATA_W'(sel2_d);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.read_data       = rd_q;
  assign out_o.pad_out_level   = lvl_o_q;
  assign out_o.pad_out_enable  = oe_o_q;
  assign out_o.pull_up_on      = pu_o_q;
  assign out_o.pull_down_on    = pd_o_q;
  assign out_o.filter_on       = flt_o_q;
  assign out_o.periph_sel_low  = sl_o_q;
  assign out_o.periph_sel_high = sh_o_q;

endmodule

// File: rtl/gpio_bank_set_clear_registers_unit.sv
// Channel  Dir  Beat
// in_i     in   one bus access: action, reg_select, write_data, pad_levels
// out_o    out  one result: read_data plus the pad control words after the access
//
// One access per cycle sustained while out_o takes every result; an access is
// decoded into the command queue, then executed in the register bank.
// While the output is stalled, the command queue holds QueueDepth accesses behind
// the waiting result; once it is full in_i.ready drops, and it rises again the
// cycle after the output takes a beat.
// Reset is asynchronous: ownership resets to all ones, every other word to zero.
module gpio_bank_set_clear_registers_unit import gbsc_pkg::*; #(
  parameter int unsigned PinCount    = PIN_COUNT,
  parameter int unsigned DividerBits = DIVIDER_BITS,
  parameter int unsigned QueueDepth  = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbsc_in_if.sink    in_i,
  gbsc_out_if.source out_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  gbsc_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  gbsc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  gbsc_back #(
    .PinCount    (PinCount),
    .DividerBits (DividerBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

// File: rtl/gbsc_checker.sv
`include "gpio_bank_set_clear_registers_unit_defines.svh"

module gbsc_checker import gbsc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] out_read_data_i,
  input logic [DATA_W-1:0] out_pad_out_enable_i
);

  // A stalled result beat holds.
  `GBSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_read_data_i) && $stable(out_pad_out_enable_i))

  // The queue only fills up behind a result beat that is waiting.
  `GBSC_ASSERT_NOW(a_full_needs_stall, clk_i, rst_ni, !in_ready_i, out_valid_i)

  // Input backpressure starts only after the output refused a beat.
  `GBSC_ASSERT_NOW(a_ready_fall, clk_i, rst_ni, $fell(in_ready_i), $past(out_valid_i && !out_ready_i && in_valid_i))

endmodule

bind gpio_bank_set_clear_registers_unit gbsc_checker u_gbsc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_read_data_i      (out_o.read_data),
  .out_pad_out_enable_i (out_o.pad_out_enable)
);

// File: tb/gbsc_tb_pkg.sv
package gbsc_tb_pkg;
  import gbsc_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pad_out_level;
    logic [DATA_W-1:0] pad_out_enable;
    logic [DATA_W-1:0] pull_up_on;
    logic [DATA_W-1:0] pull_down_on;
    logic [DATA_W-1:0] filter_on;
    logic [DATA_W-1:0] periph_sel_low;
    logic [DATA_W-1:0] periph_sel_high;
  } pin_ctrl_t;

  class pin_bank_scoreboard;
    logic [DATA_W-1:0]       owned, out_en, out_lvl, filt, debounce, open_drn;
    logic [DATA_W-1:0]       pu_off, pd_on, sel_one, sel_two, schmitt_off;
    logic [DIVIDER_BITS-1:0] divider;
    pin_ctrl_t               pin_ctrl_q[$];
    int                      errors;

    function new();
      owned       = '1;
      out_en      = '0;
      out_lvl     = '0;
      filt        = '0;
      debounce    = '0;
      open_drn    = '0;
      pu_off      = '0;
      pd_on       = '0;
      sel_one     = '0;
      sel_two     = '0;
      schmitt_off = '0;
      divider     = '0;
      errors      = 0;
    endfunction

    // Apply one accepted bus access to the bank copy and queue its result.
    function void note_access(logic wr, reg_e sel, logic [DATA_W-1:0] data,
                              logic [DATA_W-1:0] pads);
      logic [DATA_W-1:0] rd;
      pin_ctrl_t         want;
      rd = '0;
      if (wr) begin
        case (sel)
          REG_OWN_SET:  owned       |= data;
          REG_OWN_CLR:  owned       &= ~data;
          REG_OE_SET:   out_en      |= data;
          REG_OE_CLR:   out_en      &= ~data;
          REG_LVL_SET:  out_lvl     |= data;
          REG_LVL_CLR:  out_lvl     &= ~data;
          REG_FLT_SET:  filt        |= data;
          REG_FLT_CLR:  filt        &= ~data;
          REG_DEB_SET:  debounce    |= data;
          REG_DEB_CLR:  debounce    &= ~data;
          REG_OD_SET:   open_drn    |= data;
          REG_OD_CLR:   open_drn    &= ~data;
          // pull-up status is stored inverted: enable clears the off bits
          REG_PU_EN:    pu_off      &= ~data;
          REG_PU_DIS:   pu_off      |= data;
          REG_PD_SET:   pd_on       |= data;
          REG_PD_CLR:   pd_on       &= ~data;
          REG_SEL_ONE:  sel_one     = data;
          REG_SEL_TWO:  sel_two     = data;
          REG_SCHMITT:  schmitt_off = data;
          REG_DIVIDER:  divider     = data[DIVIDER_BITS-1:0];
          REG_LEGACY_A: sel_one     &= ~data;
          REG_LEGACY_B: sel_one     |= data;
          default: ;
        endcase
      end else begin
        case (sel)
          REG_OWN_STAT: rd = owned;
          REG_OE_STAT:  rd = out_en;
          REG_LVL_STAT: rd = out_lvl;
          REG_FLT_STAT: rd = filt;
          REG_DEB_STAT: rd = debounce;
          REG_OD_STAT:  rd = open_drn;
          REG_PU_STAT:  rd = pu_off;
          REG_PD_STAT:  rd = pd_on;
          REG_SEL_ONE:  rd = sel_one;
          REG_SEL_TWO:  rd = sel_two;
          REG_SCHMITT:  rd = schmitt_off;
          REG_DIVIDER:  rd = DATA_W'(divider);
          REG_PIN_DATA: rd = pads;
          default: ;
        endcase
      end
      want.read_data       = rd;
      want.pad_out_level   = out_lvl;
      want.pad_out_enable  = owned & out_en & ~(open_drn & out_lvl);
      want.pull_up_on      = ~pu_off;
      want.pull_down_on    = pd_on;
      want.filter_on       = filt;
      want.periph_sel_low  = sel_one;
      want.periph_sel_high = sel_two;
      pin_ctrl_q.push_back(want);
    endfunction

    function void compare_word(string name, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pin_ctrl_t got);
      pin_ctrl_t want;
      if (pin_ctrl_q.size() == 0) begin
        $error("result beat with nothing pending: read_data %h", got.read_data);
        errors++;
        return;
      end
      want = pin_ctrl_q.pop_front();
      compare_word("read_data",       want.read_data,       got.read_data);
      compare_word("pad_out_level",   want.pad_out_level,   got.pad_out_level);
      compare_word("pad_out_enable",  want.pad_out_enable,  got.pad_out_enable);
      compare_word("pull_up_on",      want.pull_up_on,      got.pull_up_on);
      compare_word("pull_down_on",    want.pull_down_on,    got.pull_down_on);
      compare_word("filter_on",       want.filter_on,       got.filter_on);
      compare_word("periph_sel_low",  want.periph_sel_low,  got.periph_sel_low);
      compare_word("periph_sel_high", want.periph_sel_high, got.periph_sel_high);
    endfunction

    function int pending();
      return pin_ctrl_q.size();
    endfunction
  endclass

endpackage

// File: tb/gpio_bank_set_clear_registers_unit_tb.sv
module gpio_bank_set_clear_registers_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbsc_pkg::*;
  import gbsc_tb_pkg::*;

  localparam int RANDOM_PER_PHASE = 450;
  localparam int CYCLE_LIMIT      = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  int                 send_idle_pct = 29;
  int                 recv_idle_pct = 70;
  pin_bank_scoreboard bank_sb;
  pin_ctrl_t          seen_ctrl;

  gbsc_in_if  in_ch ();
  gbsc_out_if out_ch ();

  gpio_bank_set_clear_registers_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #2 clk = ~clk;

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.action     = 1'b0;
    in_ch.reg_select = '0;
    in_ch.write_data = '0;
    in_ch.pad_levels = '0;
    out_ch.ready     = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        bank_sb.note_access(in_ch.action, reg_e'(in_ch.reg_select), in_ch.write_data,
                            in_ch.pad_levels);
      if (out_ch.valid && out_ch.ready) begin
        seen_ctrl.read_data       = out_ch.read_data;
        seen_ctrl.pad_out_level   = out_ch.pad_out_level;
        seen_ctrl.pad_out_enable  = out_ch.pad_out_enable;
        seen_ctrl.pull_up_on      = out_ch.pull_up_on;
        seen_ctrl.pull_down_on    = out_ch.pull_down_on;
        seen_ctrl.filter_on       = out_ch.filter_on;
        seen_ctrl.periph_sel_low  = out_ch.periph_sel_low;
        seen_ctrl.periph_sel_high = out_ch.periph_sel_high;
        bank_sb.check_result(seen_ctrl);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Hold the beat until the block takes it; idle gaps go in front.
  task automatic send_access(input logic wr, input reg_e sel,
                             input logic [DATA_W-1:0] data,
                             input logic [DATA_W-1:0] pads);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= wr;
    in_ch.reg_select <= sel;
    in_ch.write_data <= data;
    in_ch.pad_levels <= pads;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [DATA_W-1:0] pick_mask();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return DATA_W'(1) << $urandom_range(DATA_W - 1);
      3: return ~(DATA_W'(1) << $urandom_range(DATA_W - 1));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_access();
    send_access(1'($urandom_range(1)), reg_e'($urandom_range(31)), pick_mask(),
                $urandom);
  endtask

  initial begin
    bank_sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then each register family at its extremes
    send_access(1'b0, REG_OWN_STAT, '0, '0);
    send_access(1'b0, REG_PU_STAT,  '0, '1);
    send_access(1'b1, REG_OE_SET,   '1, '0);
    send_access(1'b1, REG_LVL_SET,  32'hAAAA_5555, '0);
    send_access(1'b1, REG_OD_SET,   '1, '0);
    send_access(1'b1, REG_OWN_CLR,  32'h0000_FFFF, '0);
    send_access(1'b0, REG_OWN_STAT, '0, '0);
    send_access(1'b1, REG_PU_DIS,   '1, '0);
    send_access(1'b1, REG_PU_EN,    32'h8000_0001, '0);
    send_access(1'b0, REG_PU_STAT,  '0, '0);
    send_access(1'b1, REG_PD_SET,   '1, '0);
    send_access(1'b1, REG_FLT_SET,  '1, '0);
    send_access(1'b1, REG_DEB_SET,  32'h0000_0001, '0);
    send_access(1'b1, REG_SEL_ONE,  32'hFFFF_0000, '0);
    send_access(1'b1, REG_LEGACY_A, 32'hFF00_0000, '0);
    send_access(1'b1, REG_LEGACY_B, 32'h0000_00FF, '0);
    send_access(1'b1, REG_SEL_TWO,  '1, '0);
    send_access(1'b1, REG_SCHMITT,  32'h8000_0000, '0);
    send_access(1'b0, REG_SCHMITT,  '0, '0);
    // divider keeps only its low bits
    send_access(1'b1, REG_DIVIDER,  '1, '0);
    send_access(1'b0, REG_DIVIDER,  '0, '0);
    send_access(1'b0, REG_PIN_DATA, '0, '1);
    send_access(1'b1, REG_IRQ_DIS,  '1, '1);
    // write-only reads zero, read-only ignores writes
    send_access(1'b0, REG_OD_SET,   '1, '0);
    send_access(1'b1, REG_LVL_STAT, '0, '0);
    send_access(1'b1, REG_PIN_DATA, '1, '0);

    repeat (RANDOM_PER_PHASE) random_access();
    send_idle_pct = 70;
    recv_idle_pct = 29;
    repeat (RANDOM_PER_PHASE) random_access();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) random_access();
    in_ch.valid <= 1'b0;

    while (bank_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bank_sb.errors == 0 && bank_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
